// File: design/biquad_cascade_lowpass_assert.svh
// Assertion macros for the biquad cascade low-pass filter.
`ifndef BIQUAD_CASCADE_LOWPASS_ASSERT_SVH
`define BIQUAD_CASCADE_LOWPASS_ASSERT_SVH

// same-cycle implication
`define BQC_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bqc assertion failed");

// next-cycle implication
`define BQC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bqc assertion failed");

`endif

// File: design/bqc_pkg.sv
// Shared constants, coefficient table, types and helpers for the biquad cascade.
package bqc_pkg;

    localparam int DEF_SECTIONS    = 3;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int MAX_SECTIONS    = 8;
    localparam int SEC_IDX_BITS    = 3;

    localparam int INT_BITS   = 48;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_BITS  = 32;
    localparam int COEF_FRAC  = 30;
    localparam int DIGIT_BITS = 8;
    localparam int PROD_BITS  = COEF_BITS + INT_BITS;
    localparam int MUL_BITS   = PROD_BITS - COEF_FRAC;
    localparam int SUM_BITS   = 52;

    localparam int NUM_COEFS     = 5;
    localparam int COEF_IDX_BITS = 3;
    localparam logic [COEF_IDX_BITS-1:0] COEF_B0 = 3'd0;
    localparam logic [COEF_IDX_BITS-1:0] COEF_B1 = 3'd1;
    localparam logic [COEF_IDX_BITS-1:0] COEF_B2 = 3'd2;
    localparam logic [COEF_IDX_BITS-1:0] COEF_A1 = 3'd3;
    localparam logic [COEF_IDX_BITS-1:0] COEF_A2 = 3'd4;

    // b0, b1, b2, a1, a2 in Q2.30; sections past the third pass through
    localparam logic signed [COEF_BITS-1:0] COEF_TAB [MAX_SECTIONS][NUM_COEFS] = '{
        '{ 32'sd711741,     32'sd888261,     32'sd711741,
          -32'sd1661309318, 32'sd661138996 },
        '{ 32'sd1073741824, -32'sd518885000,  32'sd1073741824,
          -32'sd1676059312, 32'sd790187310 },
        '{ 32'sd1073741824, -32'sd1045826866, 32'sd1073741824,
          -32'sd1743490408, 32'sd973300544 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 }
    };

    typedef struct packed {
        logic                        start;
        logic signed [COEF_BITS-1:0] coef;
        logic signed [INT_BITS-1:0]  operand;
    } mac_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [MUL_BITS-1:0] prod;
    } mac_rsp_t;

    typedef struct packed {
        logic                       load;
        logic signed [INT_BITS-1:0] value;
    } out_req_t;

    function automatic logic signed [COEF_BITS-1:0] coef_lookup(
        input logic [SEC_IDX_BITS-1:0]  sec,
        input logic [COEF_IDX_BITS-1:0] idx
    );
        logic signed [COEF_BITS-1:0] c;
        c = '0;
        if (idx < COEF_IDX_BITS'(NUM_COEFS))
        begin
            c = COEF_TAB[sec][idx];
        end
        return c;
    endfunction

    function automatic logic signed [INT_BITS-1:0] sat_int(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-INT_BITS:0] hi;
        logic signed [INT_BITS-1:0] r;
        hi = v[SUM_BITS-1:INT_BITS-1];
        if ((&hi) || !(|hi))
        begin
            r = v[INT_BITS-1:0];
        end
        else if (v[SUM_BITS-1])
        begin
            r = {1'b1, {(INT_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(INT_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: design/bqc_mac.sv
// Digit-serial multiplier: coefficient shifted out 8 bits per cycle, Q2.30 rounding.
module bqc_mac
    import bqc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_req_t req,
    output mac_rsp_t rsp
);

    localparam int DIGITS  = COEF_BITS / DIGIT_BITS;
    localparam int CNT_W   = $clog2(DIGITS);
    localparam int PP_BITS = INT_BITS + DIGIT_BITS + 1;
    localparam logic signed [PROD_BITS-1:0] RND_ADD = PROD_BITS'(1) <<< (COEF_FRAC - 1);

    logic [COEF_BITS-1:0]        coef_sr_reg;
    logic signed [INT_BITS-1:0]  opnd_reg;
    logic signed [PROD_BITS-1:0] acc_reg;
    logic signed [PROD_BITS-1:0] acc_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        done_next;

    logic [DIGIT_BITS-1:0]       digit;
    logic signed [DIGIT_BITS:0]  digit_ext;
    logic signed [PP_BITS-1:0]   pp;
    logic signed [PROD_BITS-1:0] acc_base;
    logic                        first;
    logic                        last;

    always_comb
    begin
        digit     = coef_sr_reg[COEF_BITS-1 -: DIGIT_BITS];
        first     = (cnt_reg == '0);
        last      = (cnt_reg == CNT_W'(DIGITS - 1));
        // top digit carries the coefficient sign
        digit_ext = first ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
        pp        = PP_BITS'(opnd_reg) * PP_BITS'(digit_ext);
        acc_base  = first ? '0 : (acc_reg <<< DIGIT_BITS);
        acc_next  = acc_base + PROD_BITS'(pp) + (last ? RND_ADD : '0);
        done_next = busy_reg && last && !req.start;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg[PROD_BITS-1:COEF_FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            coef_sr_reg <= req.coef;
            opnd_reg    <= req.operand;
        end
        else if (busy_reg)
        begin
            coef_sr_reg <= coef_sr_reg << DIGIT_BITS;
            acc_reg     <= acc_next;
        end
    end

endmodule

// File: design/bqc_out.sv
// Output stage: rounds to sample width, saturates, holds the result transaction.
module bqc_out
    import bqc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  out_req_t                      req,
    output logic                          can_load,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int R_BITS = INT_BITS + 1 - FRAC_BITS;
    localparam logic signed [INT_BITS:0]  RND  = (INT_BITS + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [R_BITS-1:0]  SMAX =
        R_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [R_BITS-1:0]  SMIN = R_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic signed [INT_BITS:0]       rsum;
    logic signed [R_BITS-1:0]       r;
    logic signed [R_BITS-1:0]       rc;
    logic                           fire;
    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_BITS-1:0]  samp_reg;
    logic                           clip_reg;
    logic                           clip_next;

    always_comb
    begin
        rsum      = (INT_BITS + 1)'(req.value) + RND;
        r         = rsum[INT_BITS:FRAC_BITS];
        clip_next = 1'b0;
        rc        = r;
        if (r > SMAX)
        begin
            rc        = SMAX;
            clip_next = 1'b1;
        end
        else if (r < SMIN)
        begin
            rc        = SMIN;
            clip_next = 1'b1;
        end
        can_load   = !valid_reg || out_ready;
        fire       = req.load && can_load;
        valid_next = fire || (valid_reg && !out_ready);
    end

    assign sample_out = samp_reg;
    assign saturated  = clip_reg;
    assign out_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            samp_reg <= rc[SAMPLE_BITS-1:0];
            clip_reg <= clip_next;
        end
    end

endmodule

// File: design/biquad_cascade_lowpass.sv
// Top level: cascade of transposed direct form II biquads on one shared digit-serial multiplier.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, sample_in    | into block
//  output  | out_valid, out_ready, sample_out,| out of block
//          | saturated                        |
//
// Each sample takes five products per section on the shared multiplier, each product
// stepping through issue, four 8-bit coefficient digits and accumulate.
// Reset clears the delay registers; no clearing pass.
// A stalled output holds the next result in the done state, where no new input transaction
// is taken; one is taken while only the output register holds a waiting result.
module biquad_cascade_lowpass
    import bqc_pkg::*;
#(
    parameter int SECTIONS    = DEF_SECTIONS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [2:0] STEP_Y   = 3'd0;
    localparam logic [2:0] STEP_Z0B = 3'd1;
    localparam logic [2:0] STEP_Z0A = 3'd2;
    localparam logic [2:0] STEP_Z1B = 3'd3;
    localparam logic [2:0] STEP_Z1A = 3'd4;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [2:0]                 step_reg;
    logic [2:0]                 step_next;
    logic [SEC_W-1:0]           sec_reg;
    logic [SEC_W-1:0]           sec_next;
    logic signed [INT_BITS-1:0] u_reg;
    logic signed [INT_BITS-1:0] u_next;
    logic signed [INT_BITS-1:0] y_reg;
    logic signed [INT_BITS-1:0] y_next;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [INT_BITS-1:0] z0_reg [SECTIONS];
    logic signed [INT_BITS-1:0] z1_reg [SECTIONS];
    logic                       z0_we;
    logic                       z1_we;

    logic [COEF_IDX_BITS-1:0]   coef_idx;
    logic                       use_y;
    logic                       neg;
    logic signed [SUM_BITS-1:0] base;
    logic signed [SUM_BITS-1:0] m_ext;
    logic signed [SUM_BITS-1:0] sum_calc;
    logic signed [INT_BITS-1:0] sat_val;

    mac_req_t mac_req;
    mac_rsp_t mac_rsp;
    out_req_t out_req;
    logic     out_can_load;

    always_comb
    begin
        unique case (step_reg)
            STEP_Y:
            begin
                coef_idx = COEF_B0;
                use_y    = 1'b0;
                base     = SUM_BITS'(z0_reg[sec_reg]);
                neg      = 1'b0;
            end
            STEP_Z0B:
            begin
                coef_idx = COEF_B1;
                use_y    = 1'b0;
                base     = SUM_BITS'(z1_reg[sec_reg]);
                neg      = 1'b0;
            end
            STEP_Z0A:
            begin
                coef_idx = COEF_A1;
                use_y    = 1'b1;
                base     = sum_reg;
                neg      = 1'b1;
            end
            STEP_Z1B:
            begin
                coef_idx = COEF_B2;
                use_y    = 1'b0;
                base     = '0;
                neg      = 1'b0;
            end
            STEP_Z1A:
            begin
                coef_idx = COEF_A2;
                use_y    = 1'b1;
                base     = sum_reg;
                neg      = 1'b1;
            end
            default:
            begin
                coef_idx = COEF_B0;
                use_y    = 1'b0;
                base     = '0;
                neg      = 1'b0;
            end
        endcase
        m_ext    = SUM_BITS'(mac_rsp.prod);
        sum_calc = neg ? (base - m_ext) : (base + m_ext);
        sat_val  = sat_int(sum_calc);
    end

    always_comb
    begin
        mac_req.coef    = coef_lookup(SEC_IDX_BITS'(sec_reg), coef_idx);
        mac_req.operand = use_y ? y_reg : u_reg;
        out_req.value   = u_reg;
        state_next    = state_reg;
        step_next     = step_reg;
        sec_next      = sec_reg;
        u_next        = u_reg;
        y_next        = y_reg;
        sum_next      = sum_reg;
        z0_we         = 1'b0;
        z1_we         = 1'b0;
        in_ready      = 1'b0;
        mac_req.start = 1'b0;
        out_req.load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    u_next     = INT_BITS'(sample_in) <<< FRAC_BITS;
                    sec_next   = '0;
                    step_next  = STEP_Y;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                mac_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mac_rsp.done)
                begin
                    sum_next   = sum_calc;
                    state_next = ST_ISSUE;
                    if (step_reg == STEP_Y)
                    begin
                        y_next = sat_val;
                    end
                    if (step_reg == STEP_Z0A)
                    begin
                        z0_we = 1'b1;
                    end
                    if (step_reg == STEP_Z1A)
                    begin
                        z1_we     = 1'b1;
                        u_next    = y_reg;
                        step_next = STEP_Y;
                        if (sec_reg == SEC_LAST)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            sec_next = sec_reg + SEC_W'(1);
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            ST_DONE:
            begin
                out_req.load = 1'b1;
                if (out_can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_Y;
            sec_reg   <= '0;
            for (int i = 0; i < SECTIONS; i++)
            begin
                z0_reg[i] <= '0;
                z1_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sec_reg   <= sec_next;
            if (z0_we)
            begin
                z0_reg[sec_reg] <= sat_val;
            end
            if (z1_we)
            begin
                z1_reg[sec_reg] <= sat_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        y_reg   <= y_next;
        sum_reg <= sum_next;
    end

    bqc_mac u_mac
    (
        .clk (clk),
        .rst_n (rst_n),
        .req (mac_req),
        .rsp (mac_rsp)
    );

    bqc_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (out_req),
        .can_load   (out_can_load),
        .sample_out (sample_out),
        .saturated  (saturated),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// File: design/bqc_checker.sv
// Port-level checker for the biquad cascade, bound to the top level.
`include "biquad_cascade_lowpass_assert.svh"

module bqc_checker
    import bqc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic                   saturated
);

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    `BQC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(saturated))
    `BQC_ASSERT_IMPL(a_sat_value, clk, rst_n, out_valid && saturated, sample_out == S_MAX || sample_out == S_MIN)
    `BQC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `BQC_ASSERT_IMPL(a_out_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind biquad_cascade_lowpass bqc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);
